>>> sv/rls_pkg.sv
// ----------------------------------------------------------------------------
// rls_pkg
// Shared types and constants of the reflectance line steering block:
// payload structs, register indexes, steering codes and the lane control
// and status groups.
// ----------------------------------------------------------------------------
package rls_pkg;

  localparam int unsigned NUM_CH  = 5;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned CODE_W  = 4;
  localparam int unsigned CIDX_W  = 3;

  localparam logic [CIDX_W-1:0] REG_TIMEOUT   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [CIDX_W-1:0] REG_LEFT_BASE = 3'd2;
  localparam logic [CIDX_W-1:0] REG_RIGHT_BASE = 3'd3;
  localparam logic [CIDX_W-1:0] REG_OFF_SMALL = 3'd4;
  localparam logic [CIDX_W-1:0] REG_OFF_MEDIUM = 3'd5;
  localparam logic [CIDX_W-1:0] REG_OFF_LARGE = 3'd6;
  localparam logic [CIDX_W-1:0] REG_OFF_MAX   = 3'd7;

  localparam logic [CFG_W-1:0]  RST_TIMEOUT    = 16'h0B00;
  localparam logic [CFG_W-1:0]  RST_THRESHOLD  = 16'h0400;
  localparam logic [DUTY_W-1:0] RST_LEFT_BASE  = 8'd50;
  localparam logic [DUTY_W-1:0] RST_RIGHT_BASE = 8'd50;
  localparam logic [DUTY_W-1:0] RST_OFF_SMALL  = 8'd25;
  localparam logic [DUTY_W-1:0] RST_OFF_MEDIUM = 8'd30;
  localparam logic [DUTY_W-1:0] RST_OFF_LARGE  = 8'd35;
  localparam logic [DUTY_W-1:0] RST_OFF_MAX    = 8'd40;

  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [CODE_W-1:0] STEER_LEFT_MAX    = 4'd0;
  localparam logic [CODE_W-1:0] STEER_LEFT_LARGE  = 4'd1;
  localparam logic [CODE_W-1:0] STEER_LEFT_MEDIUM = 4'd2;
  localparam logic [CODE_W-1:0] STEER_LEFT_SMALL  = 4'd3;
  localparam logic [CODE_W-1:0] STEER_CENTER      = 4'd4;
  localparam logic [CODE_W-1:0] STEER_RIGHT_SMALL = 4'd5;
  localparam logic [CODE_W-1:0] STEER_RIGHT_MEDIUM = 4'd6;
  localparam logic [CODE_W-1:0] STEER_RIGHT_LARGE = 4'd7;
  localparam logic [CODE_W-1:0] STEER_RIGHT_MAX   = 4'd8;
  localparam logic [CODE_W-1:0] STEER_LOST        = 4'd9;

  typedef struct packed {
    logic              operation;
    logic [NUM_CH-1:0] sensor_pins;
  } in_t;

  typedef struct packed {
    logic [NUM_CH-1:0] line_bits;
    logic [CODE_W-1:0] steer_code;
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
  } out_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left_base;
    logic [DUTY_W-1:0] right_base;
    logic [DUTY_W-1:0] off_small;
    logic [DUTY_W-1:0] off_medium;
    logic [DUTY_W-1:0] off_large;
    logic [DUTY_W-1:0] off_max;
  } duty_cfg_t;

  typedef struct packed {
    logic begin_rd;
    logic tick_en;
    logic timeout_hit;
    logic group_clr;
  } lane_ctrl_t;

  typedef struct packed {
    logic cap_nxt;
    logic line_hit;
  } lane_stat_t;

endpackage

>>> sv/rls_lane.sv
// ----------------------------------------------------------------------------
// rls_lane
// One sensor channel: edge capture against the previous pin level, the
// saturating discharge-time accumulator and the line threshold compare.
// ----------------------------------------------------------------------------
module rls_lane #(
  parameter int unsigned VAL_W         = 16,
  parameter int unsigned READINGS_LOG2 = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rls_pkg::lane_ctrl_t     ctrl,
  input  logic                    pin,
  input  logic [VAL_W-1:0]        tick_val,
  input  logic [rls_pkg::CFG_W-1:0] timeout_val,
  input  logic [rls_pkg::CFG_W-1:0] threshold,
  output rls_pkg::lane_stat_t     stat
);
  import rls_pkg::*;

  localparam int unsigned ACC_W = VAL_W + READINGS_LOG2;

  logic             prev_r, prev_nxt;
  logic             cap_r, cap_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             changed;
  logic             take_timeout;
  logic [VAL_W-1:0] add_val;
  logic [ACC_W:0]   sum_wide;
  logic [ACC_W-1:0] acc_sat;

  always_comb begin
    changed      = ctrl.tick_en && (prev_r != pin) && !cap_r;
    take_timeout = ctrl.tick_en && ctrl.timeout_hit && !cap_r && !changed;
    if (changed) begin
      add_val = tick_val;
    end else if (take_timeout) begin
      add_val = VAL_W'(timeout_val);
    end else begin
      add_val = '0;
    end
    sum_wide = {1'b0, acc_r} + (ACC_W+1)'(add_val);
    acc_sat  = sum_wide[ACC_W] ? {ACC_W{1'b1}} : sum_wide[ACC_W-1:0];

    prev_nxt = prev_r;
    cap_nxt  = cap_r;
    acc_nxt  = acc_r;
    if (ctrl.begin_rd) begin
      prev_nxt = 1'b1;
      cap_nxt  = 1'b0;
    end else if (ctrl.tick_en) begin
      prev_nxt = pin;
      cap_nxt  = cap_r || changed || ctrl.timeout_hit;
      acc_nxt  = ctrl.group_clr ? '0 : acc_sat;
    end

    stat.cap_nxt  = cap_nxt;
    stat.line_hit = acc_sat[ACC_W-1 -: VAL_W] >= VAL_W'(threshold);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 1'b1;
      cap_r  <= 1'b1;
      acc_r  <= '0;
    end else begin
      prev_r <= prev_nxt;
      cap_r  <= cap_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

>>> sv/rls_merge.sv
// ----------------------------------------------------------------------------
// rls_merge
// Merge stage: priority decode of the lane line bits into a steering code,
// saturated duty offsets and the output register of the result channel.
// ----------------------------------------------------------------------------
module rls_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        bits_valid,
  input  logic [rls_pkg::NUM_CH-1:0]  bits,
  input  rls_pkg::duty_cfg_t          dcfg,
  output logic                        bits_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rls_pkg::out_t               out_data
);
  import rls_pkg::*;

  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;
  logic [CODE_W-1:0] code;
  logic [DUTY_W-1:0] off;
  logic [DUTY_W:0]   l_add, l_sub, r_add, r_sub;
  logic [DUTY_W-1:0] l_duty, r_duty;

  always_comb begin
    if (bits[0] && bits[1]) begin
      code = STEER_LEFT_LARGE;
    end else if (bits[1] && bits[2]) begin
      code = STEER_LEFT_SMALL;
    end else if (bits[2] && bits[3]) begin
      code = STEER_RIGHT_SMALL;
    end else if (bits[3] && bits[4]) begin
      code = STEER_RIGHT_LARGE;
    end else if (bits[0]) begin
      code = STEER_LEFT_MAX;
    end else if (bits[1]) begin
      code = STEER_LEFT_MEDIUM;
    end else if (bits[2]) begin
      code = STEER_CENTER;
    end else if (bits[3]) begin
      code = STEER_RIGHT_MEDIUM;
    end else if (bits[4]) begin
      code = STEER_RIGHT_MAX;
    end else begin
      code = STEER_LOST;
    end

    unique case (code)
      STEER_LEFT_MAX, STEER_RIGHT_MAX: begin
        off = dcfg.off_max;
      end
      STEER_LEFT_LARGE, STEER_RIGHT_LARGE: begin
        off = dcfg.off_large;
      end
      STEER_LEFT_MEDIUM, STEER_RIGHT_MEDIUM: begin
        off = dcfg.off_medium;
      end
      STEER_LEFT_SMALL, STEER_RIGHT_SMALL: begin
        off = dcfg.off_small;
      end
      default: begin
        off = '0;
      end
    endcase

    l_add = {1'b0, dcfg.left_base} + {1'b0, off};
    l_sub = {1'b0, dcfg.left_base} - {1'b0, off};
    r_add = {1'b0, dcfg.right_base} + {1'b0, off};
    r_sub = {1'b0, dcfg.right_base} - {1'b0, off};

    if (code == STEER_LOST) begin
      l_duty = '0;
      r_duty = '0;
    end else if (code < STEER_CENTER) begin
      l_duty = l_sub[DUTY_W] ? '0 : l_sub[DUTY_W-1:0];
      r_duty = r_add[DUTY_W] ? '1 : r_add[DUTY_W-1:0];
    end else if (code > STEER_CENTER) begin
      l_duty = l_add[DUTY_W] ? '1 : l_add[DUTY_W-1:0];
      r_duty = r_sub[DUTY_W] ? '0 : r_sub[DUTY_W-1:0];
    end else begin
      l_duty = dcfg.left_base;
      r_duty = dcfg.right_base;
    end

    bits_ready    = !out_valid_r || out_ready;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (bits_ready && bits_valid) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.line_bits  = bits;
      out_data_nxt.steer_code = code;
      out_data_nxt.left_duty  = l_duty;
      out_data_nxt.right_duty = r_duty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/reflectance_line_steering.sv
// ----------------------------------------------------------------------------
// reflectance_line_steering
// Five-channel reflectance timing with averaged line detection and a
// priority steering decoder driving two saturated motor duty values.
//
//   channel   ports                          moves per transfer
//   input     in_valid/in_ready/in_data      one begin or one tick
//   result    out_valid/out_ready/out_data   line bits, code, two duties
//   config    cfg_we/cfg_index/cfg_wdata     one register write
//
// One input item per cycle is sustained while in_ready is high; each lane
// settles its capture and accumulator in the transfer cycle. The tick that
// ends the last reading of a group sends its line bits through the lane stage
// register and then the merge output register. Reset is synchronous. A stalled
// result holds in the output register while one more result waits in the
// lane stage register; in_ready drops only when both are full.
// ----------------------------------------------------------------------------
module reflectance_line_steering #(
  parameter int unsigned READINGS_LOG2 = 2,
  parameter int unsigned TIMER_WIDTH   = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rls_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rls_pkg::out_t               out_data,
  input  logic                        cfg_we,
  input  logic [rls_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [rls_pkg::CFG_W-1:0]   cfg_wdata
);
  import rls_pkg::*;

  localparam int unsigned VAL_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
  localparam int unsigned IDX_W = (READINGS_LOG2 > 0) ? READINGS_LOG2 : 1;

  logic [CFG_W-1:0]       timeout_r, threshold_r;
  duty_cfg_t              dcfg_r;

  logic [TIMER_WIDTH-1:0] tick_r, tick_nxt, tick_inc;
  logic                   active_r, active_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic                   s1_vld_r, s1_vld_nxt;
  logic [NUM_CH-1:0]      s1_bits_r, s1_bits_nxt;

  logic                   accept;
  logic                   group_last;
  logic                   reading_end;
  logic                   merge_ready;
  lane_ctrl_t             ctrl;
  lane_stat_t [NUM_CH-1:0] stat;
  logic [NUM_CH-1:0]      cap_all;
  logic [NUM_CH-1:0]      hit_all;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r          <= RST_TIMEOUT;
      threshold_r        <= RST_THRESHOLD;
      dcfg_r.left_base   <= RST_LEFT_BASE;
      dcfg_r.right_base  <= RST_RIGHT_BASE;
      dcfg_r.off_small   <= RST_OFF_SMALL;
      dcfg_r.off_medium  <= RST_OFF_MEDIUM;
      dcfg_r.off_large   <= RST_OFF_LARGE;
      dcfg_r.off_max     <= RST_OFF_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIMEOUT:    timeout_r         <= cfg_wdata;
        REG_THRESHOLD:  threshold_r       <= cfg_wdata;
        REG_LEFT_BASE:  dcfg_r.left_base  <= cfg_wdata[DUTY_W-1:0];
        REG_RIGHT_BASE: dcfg_r.right_base <= cfg_wdata[DUTY_W-1:0];
        REG_OFF_SMALL:  dcfg_r.off_small  <= cfg_wdata[DUTY_W-1:0];
        REG_OFF_MEDIUM: dcfg_r.off_medium <= cfg_wdata[DUTY_W-1:0];
        REG_OFF_LARGE:  dcfg_r.off_large  <= cfg_wdata[DUTY_W-1:0];
        REG_OFF_MAX:    dcfg_r.off_max    <= cfg_wdata[DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_ready = !s1_vld_r || merge_ready;
    accept   = in_valid && in_ready;
    tick_inc = tick_r + TIMER_WIDTH'(1);

    ctrl.begin_rd    = accept && (in_data.operation == OP_BEGIN);
    ctrl.tick_en     = accept && (in_data.operation == OP_TICK) && active_r;
    ctrl.timeout_hit = VAL_W'(tick_inc) >= VAL_W'(timeout_r);

    for (int i = 0; i < NUM_CH; i++) begin
      cap_all[i] = stat[i].cap_nxt;
      hit_all[i] = stat[i].line_hit;
    end

    group_last     = (READINGS_LOG2 == 0) || (idx_r == {IDX_W{1'b1}});
    reading_end    = ctrl.tick_en && (&cap_all);
    ctrl.group_clr = reading_end && group_last;

    tick_nxt   = tick_r;
    active_nxt = active_r;
    idx_nxt    = idx_r;
    if (ctrl.begin_rd) begin
      tick_nxt   = '0;
      active_nxt = 1'b1;
    end else if (ctrl.tick_en) begin
      tick_nxt = tick_inc;
      if (reading_end) begin
        active_nxt = 1'b0;
        idx_nxt    = idx_r + IDX_W'(READINGS_LOG2 != 0);
      end
    end

    s1_vld_nxt  = s1_vld_r && !merge_ready;
    s1_bits_nxt = s1_bits_r;
    if (ctrl.group_clr) begin
      s1_vld_nxt  = 1'b1;
      s1_bits_nxt = hit_all;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '0;
      active_r <= 1'b0;
      idx_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      tick_r   <= tick_nxt;
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_bits_r <= s1_bits_nxt;
  end

  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    rls_lane #(
      .VAL_W         (VAL_W),
      .READINGS_LOG2 (READINGS_LOG2)
    ) u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .pin         (in_data.sensor_pins[g]),
      .tick_val    (VAL_W'(tick_inc)),
      .timeout_val (timeout_r),
      .threshold   (threshold_r),
      .stat        (stat[g])
    );
  end

  rls_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .bits_valid (s1_vld_r),
    .bits       (s1_bits_r),
    .dcfg       (dcfg_r),
    .bits_ready (merge_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for reflectance_line_steering. A queue-fed driver sends
// begin and tick transfers built as sensor readings with random capture
// times, and a small noise share. Each accepted transfer runs through an
// in-bench model of the capture timer, the four-reading averaging and the
// steering decoder. A monitor compares every result field with the oldest
// prediction. Both sides stall at random, the result side holds off once long
// enough to back up the input, and the registers are reprogrammed between
// phases, extremes included.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rls_pkg::*;

  localparam int AVG_SHIFT    = 2;
  localparam int LONG_HOLD    = 600;
  localparam int SETTLE       = 8;
  localparam int LIMIT_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // bench copy of the registers
  logic [CFG_W-1:0] tmo_cfg = RST_TIMEOUT;
  logic [CFG_W-1:0] thr_cfg = RST_THRESHOLD;
  duty_cfg_t duty_cfg = '{RST_LEFT_BASE, RST_RIGHT_BASE, RST_OFF_SMALL,
                          RST_OFF_MEDIUM, RST_OFF_LARGE, RST_OFF_MAX};

  // bench copy of the capture state
  logic [NUM_CH-1:0] last_pins = '1;
  logic [NUM_CH-1:0] captured = '1;
  logic [15:0] tick_cnt = '0;
  logic reading_on = 1'b0;
  logic [AVG_SHIFT-1:0] reading_idx = '0;
  logic [31:0] discharge_sum [NUM_CH] = '{default: '0};

  in_t sensor_queue [$];
  out_t steer_expect [$];

  int stim_count = 0;
  int queued_total = 0;
  int transfers_in = 0;
  int results_seen = 0;
  int errors = 0;
  int settings = 0;
  int cycle_count = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_used = 1'b0;
  bit steady = 1'b0;
  bit long_hold = 1'b0;
  logic [15:0] codes_seen = '0;

  reflectance_line_steering DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void predict_steering(input in_t item);
    logic [NUM_CH-1:0] toggled;
    logic [NUM_CH-1:0] bits;
    logic [CODE_W-1:0] code;
    out_t res;
    int l, r, off;
    if (item.operation == OP_BEGIN) begin
      captured = '0;
      last_pins = '1;
      tick_cnt = '0;
      reading_on = 1'b1;
      return;
    end
    if (!reading_on) return;
    tick_cnt = tick_cnt + 1'b1;
    toggled = (last_pins ^ item.sensor_pins) & ~captured;
    last_pins = item.sensor_pins;
    for (int i = 0; i < NUM_CH; i++)
      if (toggled[i]) discharge_sum[i] += tick_cnt;
    captured |= toggled;
    if (tick_cnt >= tmo_cfg) begin
      for (int i = 0; i < NUM_CH; i++)
        if (!captured[i]) discharge_sum[i] += tmo_cfg;
      captured = '1;
    end
    if (captured != '1) return;
    reading_on = 1'b0;
    reading_idx = reading_idx + 1'b1;
    if (reading_idx != '0) return;
    for (int i = 0; i < NUM_CH; i++) begin
      bits[i] = ((discharge_sum[i] >> AVG_SHIFT) >= thr_cfg);
      discharge_sum[i] = '0;
    end
    if (bits[1:0] == 2'b11)      code = STEER_LEFT_LARGE;
    else if (bits[2:1] == 2'b11) code = STEER_LEFT_SMALL;
    else if (bits[3:2] == 2'b11) code = STEER_RIGHT_SMALL;
    else if (bits[4:3] == 2'b11) code = STEER_RIGHT_LARGE;
    else if (bits[0])            code = STEER_LEFT_MAX;
    else if (bits[1])            code = STEER_LEFT_MEDIUM;
    else if (bits[2])            code = STEER_CENTER;
    else if (bits[3])            code = STEER_RIGHT_MEDIUM;
    else if (bits[4])            code = STEER_RIGHT_MAX;
    else                         code = STEER_LOST;
    case (code)
      STEER_LEFT_MAX, STEER_RIGHT_MAX:       off = duty_cfg.off_max;
      STEER_LEFT_LARGE, STEER_RIGHT_LARGE:   off = duty_cfg.off_large;
      STEER_LEFT_MEDIUM, STEER_RIGHT_MEDIUM: off = duty_cfg.off_medium;
      STEER_LEFT_SMALL, STEER_RIGHT_SMALL:   off = duty_cfg.off_small;
      default:                               off = 0;
    endcase
    l = duty_cfg.left_base;
    r = duty_cfg.right_base;
    if (code == STEER_LOST) begin
      l = 0;
      r = 0;
    end else if (code < STEER_CENTER) begin
      l -= off;
      r += off;
    end else if (code > STEER_CENTER) begin
      l += off;
      r -= off;
    end
    res.line_bits = bits;
    res.steer_code = code;
    res.left_duty = (l < 0) ? 8'd0 : (l > 255) ? 8'd255 : 8'(l);
    res.right_duty = (r < 0) ? 8'd0 : (r > 255) ? 8'd255 : 8'(r);
    steer_expect.push_back(res);
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // driver: advance to the next queued transfer once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_steering(in_data);
        transfers_in++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sensor_queue.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= sensor_queue.pop_front();
          gap_left = steady ? 0 : $urandom_range(0, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result transfer, then hold off for a drawn stretch
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (steer_expect.size() == 0) begin
          $error("result with no prediction pending: %h", out_data);
          errors++;
        end else begin
          want = steer_expect.pop_front();
          check_field("line_bits", want.line_bits, out_data.line_bits);
          check_field("steer_code", want.steer_code, out_data.steer_code);
          check_field("left_duty", want.left_duty, out_data.left_duty);
          check_field("right_duty", want.right_duty, out_data.right_duty);
        end
        codes_seen[out_data.steer_code] = 1'b1;
        results_seen++;
        hold_left = steady ? 0 : $urandom_range(0, 4);
      end
      if (long_hold && !hold_used) begin
        hold_used = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[reflectance_line_steering] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_TIMEOUT:    tmo_cfg = val;
      REG_THRESHOLD:  thr_cfg = val;
      REG_LEFT_BASE:  duty_cfg.left_base = val[DUTY_W-1:0];
      REG_RIGHT_BASE: duty_cfg.right_base = val[DUTY_W-1:0];
      REG_OFF_SMALL:  duty_cfg.off_small = val[DUTY_W-1:0];
      REG_OFF_MEDIUM: duty_cfg.off_medium = val[DUTY_W-1:0];
      REG_OFF_LARGE:  duty_cfg.off_large = val[DUTY_W-1:0];
      REG_OFF_MAX:    duty_cfg.off_max = val[DUTY_W-1:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // 8-bit registers get random upper bits, which must be dropped
  task automatic program_regs(input int tmo, thr, lb, rb, os, om, ol, ox);
    write_reg(REG_TIMEOUT, 16'(tmo));
    write_reg(REG_THRESHOLD, 16'(thr));
    write_reg(REG_LEFT_BASE, {8'($urandom), 8'(lb)});
    write_reg(REG_RIGHT_BASE, {8'($urandom), 8'(rb)});
    write_reg(REG_OFF_SMALL, {8'($urandom), 8'(os)});
    write_reg(REG_OFF_MEDIUM, {8'($urandom), 8'(om)});
    write_reg(REG_OFF_LARGE, {8'($urandom), 8'(ol)});
    write_reg(REG_OFF_MAX, {8'($urandom), 8'(ox)});
    settings++;
  endtask

  task automatic push_item(input logic op, input logic [NUM_CH-1:0] pins);
    sensor_queue.push_back(in_t'{operation: op, sensor_pins: pins});
    queued_total++;
    stim_count++;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (transfers_in != queued_total || steer_expect.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one reading: channels marked dark discharge late, the others early
  task automatic queue_reading(input int tmo, input int win, input logic [NUM_CH-1:0] dark);
    int cap [NUM_CH];
    int stop_at;
    logic [NUM_CH-1:0] pins;
    if ($urandom_range(0, 9) == 0) begin
      push_item(OP_BEGIN, 5'($urandom));
      repeat ($urandom_range(1, 3)) push_item(OP_TICK, 5'($urandom));
    end
    stop_at = 0;
    for (int i = 0; i < NUM_CH; i++) begin
      cap[i] = dark[i] ? $urandom_range(win / 2 + 1, win + 2) : $urandom_range(1, win / 2);
      if (cap[i] > stop_at) stop_at = cap[i];
    end
    if (stop_at > tmo) stop_at = tmo;
    push_item(OP_BEGIN, 5'($urandom));
    for (int t = 1; t <= stop_at; t++) begin
      for (int i = 0; i < NUM_CH; i++)
        pins[i] = (t < cap[i]) ? 1'b1 : (t == cap[i]) ? 1'b0 : 1'($urandom);
      if ($urandom_range(0, 15) == 0) pins = 5'($urandom);
      push_item(OP_TICK, pins);
    end
    if ($urandom_range(0, 7) == 0) begin
      sensor_queue.push_back(in_t'{operation: OP_TICK, sensor_pins: 5'($urandom)});
      queued_total++;
    end
  endtask

  initial begin
    int phase, groups, tmo, thr, win, lb, rb, os, om, ol, ox;
    logic [NUM_CH-1:0] dark;
    bit calm;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // short timeout, duty registers left at reset
    write_reg(REG_TIMEOUT, 16'd3);
    write_reg(REG_THRESHOLD, 16'd2);
    settings++;
    push_item(OP_TICK, 5'h00);
    push_item(OP_BEGIN, 5'h00);
    push_item(OP_TICK, 5'h1E);
    push_item(OP_BEGIN, 5'h0A);
    push_item(OP_TICK, 5'h1F);
    push_item(OP_TICK, 5'h1C);
    push_item(OP_TICK, 5'h14);
    push_item(OP_TICK, 5'h00);
    push_item(OP_BEGIN, 5'h1F);
    push_item(OP_TICK, 5'h00);
    push_item(OP_BEGIN, 5'h00);
    push_item(OP_TICK, 5'h1F);
    push_item(OP_TICK, 5'h1F);
    push_item(OP_TICK, 5'h0F);
    push_item(OP_BEGIN, 5'h1F);
    push_item(OP_TICK, 5'h17);
    push_item(OP_TICK, 5'h13);
    push_item(OP_TICK, 5'h03);
    drain();

    phase = 0;
    while (stim_count < 1100) begin
      groups = $urandom_range(2, 5);
      calm = ($urandom_range(0, 3) == 0);
      thr = -1;
      tmo = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 65535) : $urandom_range(2, 10);
      lb = $urandom_range(0, 255);
      rb = $urandom_range(0, 255);
      os = $urandom_range(0, 255);
      om = $urandom_range(0, 255);
      ol = $urandom_range(0, 255);
      ox = $urandom_range(0, 255);
      case (phase)
        0: begin
          tmo = 1;
          thr = 0;
          lb = 0;
          rb = 0;
          {os, om, ol, ox} = {32'd255, 32'd255, 32'd255, 32'd255};
        end
        1: begin
          tmo = 65535;
          thr = 65535;
          {lb, rb, os, om, ol, ox} = {6{32'd255}};
        end
        2: begin
          tmo = 6;
          {lb, rb, os, om, ol, ox} = {6{32'd255}};
        end
        3: begin
          tmo = 2;
          groups = 14;
          calm = 1'b1;
          long_hold <= 1'b1;
        end
        default: ;
      endcase
      win = (tmo < 8) ? tmo : 8;
      if (win < 2) win = 2;
      if (thr < 0) thr = $urandom_range(win / 2, win / 2 + 2);
      steady <= calm;
      program_regs(tmo, thr, lb, rb, os, om, ol, ox);
      repeat (groups) begin
        case ($urandom_range(0, 3))
          0:       dark = 5'($urandom);
          1:       dark = 5'b00001 << $urandom_range(0, 4);
          2:       dark = 5'b00011 << $urandom_range(0, 3);
          default: dark = '0;
        endcase
        repeat (4) queue_reading(tmo, win, dark);
      end
      drain();
      phase++;
    end

    $display("Sent %0d input transfers under %0d register settings.", transfers_in, settings);
    $display("Checked %0d steering results covering %0d of 10 steering codes.",
             results_seen, $countones(codes_seen));
    if (errors == 0 && steer_expect.size() == 0) begin
      $display("[reflectance_line_steering] OK");
    end else begin
      $display("[reflectance_line_steering] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
sv/rls_pkg.sv
sv/rls_lane.sv
sv/rls_merge.sv
sv/reflectance_line_steering.sv
tb/sv/testbench.sv
